[src/hciinq_pkg.sv]
`timescale 1ns / 1ps

package hciinq_pkg;

  // H4 packet type and HCI event codes
  localparam logic [7:0] PKT_EVENT     = 8'h04;
  localparam logic [7:0] EV_INQ_DONE   = 8'h01;
  localparam logic [7:0] EV_INQ_RESULT = 8'h02;
  localparam logic [7:0] EV_INQ_RSSI   = 8'h22;
  localparam logic [7:0] NO_STATUS     = 8'hff;

  localparam logic       KIND_DEVICE = 1'b0;
  localparam logic       KIND_DONE   = 1'b1;

  localparam logic [2:0] ADDR_LAST_POS = 3'd5;
  localparam logic [15:0] SIGHT_MAX    = 16'hffff;

  // device slot within one event: at most 254 parameter bytes / 6
  localparam int DEV_W = 6;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_CODE  = 2'd1,
    PH_LEN   = 2'd2,
    PH_PARAM = 2'd3
  } phase_t;

  typedef struct packed {
    logic        hit;
    logic        kind;
    logic [47:0] addr;
    logic [7:0]  status;
    logic [15:0] count;
  } result_t;

endpackage

[src/hciinq_in_reg.sv]
`timescale 1ns / 1ps

module hciinq_in_reg
  import hciinq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       out_free,
  output logic       adv,
  output logic [7:0] byte_q
);

  logic       valid_r;
  logic [7:0] byte_r;

  // advance the held request whenever the result register can take it
  assign adv      = valid_r && out_free;
  assign in_ready = !valid_r || out_free;
  assign byte_q   = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

[src/hciinq_parser.sv]
`timescale 1ns / 1ps

module hciinq_parser
  import hciinq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  output result_t    res
);

  phase_t             phase_r, phase_nxt;
  logic [7:0]         code_r, code_nxt;
  logic [7:0]         len_r, len_nxt;
  logic [7:0]         idx_r, idx_nxt;
  logic [7:0]         total_r, total_nxt;
  logic [2:0]         pos_r, pos_nxt;
  logic [39:0]        acc_r, acc_nxt;
  logic [7:0]         status_r, status_nxt;
  logic [15:0]        sight_r, sight_nxt;
  logic [DEV_W-1:0]   dev_r, dev_nxt;
  logic               is_result_code;

  assign is_result_code = (code_r == EV_INQ_RESULT) || (code_r == EV_INQ_RSSI);

  always_comb begin
    phase_nxt  = phase_r;
    code_nxt   = code_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    total_nxt  = total_r;
    pos_nxt    = pos_r;
    acc_nxt    = acc_r;
    status_nxt = status_r;
    sight_nxt  = sight_r;
    dev_nxt    = dev_r;
    res        = '0;

    unique case (phase_r)
      PH_WAIT: begin
        if (rx_byte == PKT_EVENT) begin
          phase_nxt = PH_CODE;
        end
      end
      PH_CODE: begin
        code_nxt  = rx_byte;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt    = rx_byte;
        idx_nxt    = '0;
        total_nxt  = '0;
        status_nxt = '0;
        pos_nxt    = '0;
        acc_nxt    = '0;
        dev_nxt    = '0;
        if (rx_byte == 8'd0) begin
          // empty event ends here
          phase_nxt = PH_WAIT;
          if (code_r == EV_INQ_DONE) begin
            res.hit    = 1'b1;
            res.kind   = KIND_DONE;
            res.status = NO_STATUS;
            res.count  = sight_r;
          end
        end else begin
          phase_nxt = PH_PARAM;
        end
      end
      PH_PARAM: begin
        if (idx_r == 8'd0) begin
          status_nxt = rx_byte;
          total_nxt  = rx_byte;
        end else if (is_result_code) begin
          if (pos_r != ADDR_LAST_POS) begin
            acc_nxt[{pos_r, 3'b000} +: 8] = rx_byte;
            pos_nxt = pos_r + 3'd1;
          end else begin
            pos_nxt = '0;
            acc_nxt = '0;
            dev_nxt = dev_r + DEV_W'(1);
            if ({{(8-DEV_W){1'b0}}, dev_r} < total_r) begin
              if (sight_r != SIGHT_MAX) begin
                sight_nxt = sight_r + 16'd1;
              end
              res.hit   = 1'b1;
              res.kind  = KIND_DEVICE;
              res.addr  = {rx_byte, acc_r};
              res.count = sight_nxt;
            end
          end
        end
        idx_nxt = idx_r + 8'd1;
        if (idx_nxt >= len_r) begin
          phase_nxt = PH_WAIT;
          if (code_r == EV_INQ_DONE) begin
            res.hit    = 1'b1;
            res.kind   = KIND_DONE;
            res.addr   = '0;
            res.status = status_nxt;
            res.count  = sight_r;
          end
        end
      end
      default: begin
        phase_nxt = PH_WAIT;
      end
    endcase

    if (!fire) begin
      res.hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      code_r   <= '0;
      len_r    <= '0;
      idx_r    <= '0;
      total_r  <= '0;
      pos_r    <= '0;
      acc_r    <= '0;
      status_r <= '0;
      sight_r  <= '0;
      dev_r    <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      code_r   <= code_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
      total_r  <= total_nxt;
      pos_r    <= pos_nxt;
      acc_r    <= acc_nxt;
      status_r <= status_nxt;
      sight_r  <= sight_nxt;
      dev_r    <= dev_nxt;
    end
  end

endmodule

[src/hciinq_out_reg.sv]
`timescale 1ns / 1ps

module hciinq_out_reg
  import hciinq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  result_t     res,
  output logic        out_free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [47:0] out_device_address,
  output logic [7:0]  out_status_code,
  output logic [15:0] out_sighting_count
);

  logic    valid_r;
  result_t res_r;

  assign out_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= load && res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load && res.hit) begin
      res_r <= res;
    end
  end

  assign out_valid          = valid_r;
  assign out_result_kind    = res_r.kind;
  assign out_device_address = res_r.addr;
  assign out_status_code    = res_r.status;
  assign out_sighting_count = res_r.count;

endmodule

[src/hci_h4_inquiry_event_parser_top.sv]
// HCI H4 inquiry event parser. Feed the received H4 byte stream one byte per
// request on the in_ channel; the block frames HCI events (packet type 0x04,
// event code, parameter length, parameters) and reports on the out_ channel
// one request per discovered device of an Inquiry Result or Inquiry Result
// with RSSI event, as soon as the sixth address byte arrives, carrying the
// 48-bit address (first received byte in bits 7:0) and a saturating count of
// devices seen since reset. An Inquiry Complete event gives one request at its
// end with the status byte, or 0xff when it has no parameters. Other events
// and stray bytes are dropped. Throughput is one byte per clock while the out_
// side takes its results: each byte is held in the input register, the framing
// logic updates its state and loads the result register in the same cycle, so
// a result reaches the out_ side through the input and the result register. The
// result register parts the two sides; when it holds an untaken result, the
// input side stalls only once the next byte is waiting too.
`timescale 1ns / 1ps

module hci_h4_inquiry_event_parser_top
  import hciinq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [47:0] out_device_address,
  output logic [7:0]  out_status_code,
  output logic [15:0] out_sighting_count
);

  logic       out_free;
  logic       adv;
  logic [7:0] byte_q;
  result_t    res;

  // hold each incoming byte until the result register has room
  hciinq_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .out_free   (out_free),
    .adv        (adv),
    .byte_q     (byte_q)
  );

  // advance the framing state and build at most one result per byte
  hciinq_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (adv),
    .rx_byte (byte_q),
    .res     (res)
  );

  // register the result toward the consumer
  hciinq_out_reg u_out_reg (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (adv),
    .res                (res),
    .out_free           (out_free),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_device_address (out_device_address),
    .out_status_code    (out_status_code),
    .out_sighting_count (out_sighting_count)
  );

endmodule
